### src/histogram_inverse_cdf_sampler_top_assert.svh
// Assertion macros for the histogram inverse-CDF sampler.
`ifndef HISTOGRAM_INVERSE_CDF_SAMPLER_TOP_ASSERT_SVH
`define HISTOGRAM_INVERSE_CDF_SAMPLER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define HICS_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("hics assertion failed");
`define HICS_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("hics assertion failed");
`else
`define HICS_ASSERT_IMP(lbl, ant, con)
`define HICS_ASSERT_NXT(lbl, ant, con)
`endif
`endif

### src/hics_pkg.sv
// Package: constants, codes and types of the histogram inverse-CDF sampler.
package hics_pkg;
  localparam int MAX_BINS  = 4096;
  localparam int PROB_BITS = 16;
  localparam int TBL_DEPTH = MAX_BINS + 1;
  localparam int AW        = $clog2(TBL_DEPTH);
  localparam int EW        = 17;
  localparam int NUM_W     = 48;
  localparam int BIN_W     = 13;
  localparam int SUM_W     = 50;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_LOAD  = 2'd3;

  localparam logic [2:0] REG_BINS_X  = 3'd0;
  localparam logic [2:0] REG_BINS_Y  = 3'd1;
  localparam logic [2:0] REG_X_LOW   = 3'd2;
  localparam logic [2:0] REG_X_WIDTH = 3'd3;
  localparam logic [2:0] REG_Y_LOW   = 3'd4;
  localparam logic [2:0] REG_Y_WIDTH = 3'd5;

  localparam logic FUNC_LOAD = 1'b0;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_N_RD   = 13'b0000000000010,
    S_N_CHK  = 13'b0000000000100,
    S_SRCH   = 13'b0000000001000,
    S_S_CHK  = 13'b0000000010000,
    S_DIV_B  = 13'b0000000100000,
    S_E0_RD  = 13'b0000001000000,
    S_E1_RD  = 13'b0000010000000,
    S_E_CHK  = 13'b0000100000000,
    S_MUL    = 13'b0001000000000,
    S_DIV_F  = 13'b0010000000000,
    S_SUM    = 13'b0100000000000,
    S_FIN    = 13'b1000000000000
  } state_t;
endpackage

### src/histogram_inverse_cdf_sampler_top.sv
// Top level of the histogram inverse-CDF sampler.
// One request at a time. A draw reads the table total, binary-searches the
// cumulative table (up to 13 probes on the single RAM port), splits the bin
// index with a 13-step shift-subtract divider, reads two entries, and, when
// interpolating, runs a 48-step divider. A draw ends early when the table
// total is zero. The table has no reset; every entry a draw touches must be
// loaded first. Results sit in an output register, so a finished result may
// wait while the next request is taken.
module histogram_inverse_cdf_sampler_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // entry_index, entry_value, rand_a, rand_b, zero pad
  input  logic [0:0]  in_tuser,  // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // x_sample, y_sample
  output logic [1:0]  out_tuser, // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_data
);
  import hics_pkg::*;

  `include "histogram_inverse_cdf_sampler_top_assert.svh"

  state_t state_r, state_nxt;

  logic [12:0] bins_x_r, bins_y_r;
  logic [31:0] x_low_r, y_low_r;
  logic [30:0] x_w_r, y_w_r;

  logic [16:0] ra_r;
  logic [15:0] rb_r;
  logic [BIN_W-1:0] bx_r, n_r, above_r, below_r, mid_r, ib_r, binx_r, biny_r;
  logic [EW-1:0] e0_r, e1_r;
  logic interp_r;
  logic [1:0] st_r;
  logic [NUM_W-1:0] q_r;
  logic [EW-1:0] rem_r, d_r;
  logic [5:0] cnt_r;
  logic [43:0] px_r, py_r;
  logic [30:0] pyb_r;
  logic [31:0] rx_r, ry_r;
  logic [1:0] rst_st_r;
  logic out_valid_r;
  logic [31:0] out_x_r, out_y_r;
  logic [1:0] out_st_r;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [EW-1:0] ram_rdata;

  logic in_acc;
  logic [12:0] in_idx;
  logic [16:0] in_val;
  logic [BIN_W-1:0] bx_eff, by_eff, n_eff;
  logic [25:0] n_prod;
  logic [13:0] mid_sum;
  logic [BIN_W-1:0] mid_c;
  logic [17:0] rem_sh;
  logic div_ge;
  logic [EW-1:0] rem_new;
  logic [NUM_W-1:0] q_new;
  logic [46:0] pyb_prod;
  logic [SUM_W-1:0] xs, ys;
  logic [31:0] xs_sat, ys_sat;
  logic fin_go;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign in_idx     = in_tdata[12:0];
  assign in_val     = in_tdata[29:13];
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_st_r;
  assign fin_go     = (state_r == S_FIN) && (!out_valid_r || out_tready);

  assign bx_eff = (bins_x_r == '0) ? BIN_W'(1) :
                  (bins_x_r > BIN_W'(MAX_BINS)) ? BIN_W'(MAX_BINS) : bins_x_r;
  assign by_eff = (bins_y_r == '0) ? BIN_W'(1) :
                  (bins_y_r > BIN_W'(MAX_BINS)) ? BIN_W'(MAX_BINS) : bins_y_r;
  assign n_prod = 26'(bx_eff) * 26'(by_eff);
  assign n_eff  = (n_prod > 26'(MAX_BINS)) ? BIN_W'(MAX_BINS) : n_prod[BIN_W-1:0];

  assign mid_sum = {1'b0, above_r} + {1'b0, below_r};
  assign mid_c   = mid_sum[13:1];

  assign rem_sh  = {rem_r, q_r[NUM_W-1]};
  assign div_ge  = rem_sh >= {1'b0, d_r};
  assign rem_new = div_ge ? 17'(rem_sh - {1'b0, d_r}) : rem_sh[EW-1:0];
  assign q_new   = {q_r[NUM_W-2:0], div_ge};

  assign pyb_prod = 47'(y_w_r) * 47'(rb_r);

  assign ram_we = in_acc && (in_tuser[0] == FUNC_LOAD) && (in_idx <= 13'(MAX_BINS));

  always_comb begin
    ram_addr = in_idx;
    case (state_r)
      S_N_RD:  ram_addr = n_r;
      S_SRCH:  ram_addr = 13'(mid_c - 13'd1);
      S_E0_RD: ram_addr = ib_r;
      S_E1_RD: ram_addr = 13'(ib_r + 13'd1);
      default: ram_addr = in_idx;
    endcase
  end

  hics_ram #(.WIDTH(EW), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_val),
    .rdata (ram_rdata)
  );

  assign xs = {{18{x_low_r[31]}}, x_low_r} + {6'b0, px_r}
            + (interp_r ? {2'b0, q_r} : '0);
  assign ys = {{18{y_low_r[31]}}, y_low_r} + {6'b0, py_r} + {19'b0, pyb_r};

  always_comb begin
    xs_sat = xs[31:0];
    if (!xs[SUM_W-1] && (xs[SUM_W-2:31] != '0)) xs_sat = 32'h7fffffff;
    if (xs[SUM_W-1] && (xs[SUM_W-2:31] != '1)) xs_sat = 32'h80000000;
    ys_sat = ys[31:0];
    if (!ys[SUM_W-1] && (ys[SUM_W-2:31] != '0)) ys_sat = 32'h7fffffff;
    if (ys[SUM_W-1] && (ys[SUM_W-2:31] != '1)) ys_sat = 32'h80000000;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = (in_tuser[0] == FUNC_LOAD) ? S_FIN : S_N_RD;
      S_N_RD:  state_nxt = S_N_CHK;
      S_N_CHK: state_nxt = (ram_rdata == '0) ? S_FIN : S_SRCH;
      S_SRCH:  state_nxt = (13'(above_r - below_r) > 13'd1) ? S_S_CHK : S_DIV_B;
      S_S_CHK: state_nxt = (ra_r == ram_rdata) ? S_DIV_B : S_SRCH;
      S_DIV_B: if (cnt_r == 6'd1) state_nxt = S_E0_RD;
      S_E0_RD: state_nxt = S_E1_RD;
      S_E1_RD: state_nxt = S_E_CHK;
      S_E_CHK: state_nxt = S_MUL;
      S_MUL:   state_nxt = interp_r ? S_DIV_F : S_SUM;
      S_DIV_F: if (cnt_r == 6'd1) state_nxt = S_SUM;
      S_SUM:   state_nxt = S_FIN;
      S_FIN:   if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bins_x_r    <= 13'd1;
      bins_y_r    <= 13'd1;
      x_low_r     <= '0;
      y_low_r     <= '0;
      x_w_r       <= 31'd65536;
      y_w_r       <= 31'd65536;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_addr)
          REG_BINS_X:  bins_x_r <= cfg_data[12:0];
          REG_BINS_Y:  bins_y_r <= cfg_data[12:0];
          REG_X_LOW:   x_low_r  <= cfg_data;
          REG_X_WIDTH: x_w_r    <= cfg_data[30:0];
          REG_Y_LOW:   y_low_r  <= cfg_data;
          REG_Y_WIDTH: y_w_r    <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_x_r  <= rx_r;
      out_y_r  <= ry_r;
      out_st_r <= rst_st_r;
    end
    case (state_r)
      S_IDLE: begin
        ra_r     <= in_tdata[46:30];
        rb_r     <= in_tdata[62:47];
        bx_r     <= bx_eff;
        n_r      <= n_eff;
        rx_r     <= '0;
        ry_r     <= '0;
        rst_st_r <= ST_LOAD;
      end
      S_N_CHK: begin
        above_r  <= 13'(n_r + 13'd1);
        below_r  <= '0;
        rst_st_r <= ST_EMPTY;
        if (ram_rdata == '0) begin
          rx_r <= '0;
          ry_r <= '0;
        end
      end
      S_SRCH: begin
        mid_r <= mid_c;
        if (13'(above_r - below_r) <= 13'd1) begin
          ib_r  <= (below_r == '0) ? '0 : 13'(below_r - 13'd1);
          q_r   <= {((below_r == '0) ? 13'd0 : 13'(below_r - 13'd1)), 35'b0};
          rem_r <= '0;
          d_r   <= {4'b0, bx_r};
          cnt_r <= 6'(BIN_W);
        end
      end
      S_S_CHK: begin
        if (ra_r == ram_rdata) begin
          ib_r  <= 13'(mid_r - 13'd1);
          q_r   <= {13'(mid_r - 13'd1), 35'b0};
          rem_r <= '0;
          d_r   <= {4'b0, bx_r};
          cnt_r <= 6'(BIN_W);
        end else if (ra_r < ram_rdata) begin
          above_r <= mid_r;
        end else begin
          below_r <= mid_r;
        end
      end
      S_DIV_B, S_DIV_F: begin
        q_r   <= q_new;
        rem_r <= rem_new;
        cnt_r <= 6'(cnt_r - 6'd1);
        if (state_r == S_DIV_B && cnt_r == 6'd1) begin
          binx_r <= rem_new[BIN_W-1:0];
          biny_r <= q_new[BIN_W-1:0];
        end
      end
      S_E1_RD: e0_r <= ram_rdata;
      S_E_CHK: begin
        e1_r     <= ram_rdata;
        interp_r <= (ra_r > e0_r) && (ram_rdata > e0_r);
        rst_st_r <= ((ra_r > e0_r) && !(ram_rdata > e0_r)) ? ST_ZERO : ST_OK;
      end
      S_MUL: begin
        px_r  <= 44'(binx_r) * 44'(x_w_r);
        py_r  <= 44'(biny_r) * 44'(y_w_r);
        pyb_r <= pyb_prod[46:PROB_BITS];
        q_r   <= 48'(x_w_r) * 48'(17'(ra_r - e0_r));
        rem_r <= '0;
        d_r   <= 17'(e1_r - e0_r);
        cnt_r <= 6'(NUM_W);
      end
      S_SUM: begin
        rx_r <= xs_sat;
        ry_r <= ys_sat;
      end
      default: ;
    endcase
  end

  `HICS_ASSERT_NXT(a_draw_starts, in_acc && in_tuser[0] != FUNC_LOAD, state_r == S_N_RD)
  `HICS_ASSERT_NXT(a_load_done, in_acc && in_tuser[0] == FUNC_LOAD, state_r == S_FIN)
  `HICS_ASSERT_IMP(a_div_nonzero, state_r == S_DIV_F || state_r == S_DIV_B, d_r != '0)
  `HICS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

### src/hics_ram.sv
// Generic single-port RAM with registered read.
module hics_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### dv/histogram_inverse_cdf_sampler_top_tb.sv
// Testbench for the histogram inverse-CDF sampler: directed and random requests checked against a local predictor.
module histogram_inverse_cdf_sampler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hics_pkg::*;

  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [1:0]  st;
  } sample_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_addr;
  logic [31:0] cfg_data;

  // predictor copy of registers and table
  logic [16:0] cdf_tbl [0:MAX_BINS];
  logic [12:0] bins_x_m, bins_y_m;
  logic [31:0] x_low_m, y_low_m;
  logic [30:0] x_width_m, y_width_m;

  sample_t     samples_due[$];
  int          fails;
  int          n_draws, n_loads;
  int          st_seen [4];
  int          burst_left;
  longint      cycles;
  bit          hold_req;
  int          hold_cnt;

  histogram_inverse_cdf_sampler_top i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic sample_t predict_sample(logic [16:0] ra, logic [15:0] rb);
    sample_t s;
    longint  bx, by, n, above, below, mid, bin, binx, biny, xs, ys;
    logic [16:0] e0, e1;
    bit      hit;
    bx = (bins_x_m == 0) ? 1 : bins_x_m;
    by = (bins_y_m == 0) ? 1 : bins_y_m;
    if (bx > MAX_BINS) bx = MAX_BINS;
    if (by > MAX_BINS) by = MAX_BINS;
    n = bx * by;
    if (n > MAX_BINS) n = MAX_BINS;
    s.st = ST_OK;
    if (cdf_tbl[n] == 0) begin
      s.x = '0;
      s.y = '0;
      s.st = ST_EMPTY;
      return s;
    end
    above = n + 1;
    below = 0;
    hit = 0;
    bin = 0;
    while (!hit && above - below > 1) begin
      mid = (above + below) / 2;
      if (ra == cdf_tbl[mid-1]) begin
        bin = mid - 1;
        hit = 1;
      end else if (ra < cdf_tbl[mid-1]) above = mid;
      else below = mid;
    end
    if (!hit) bin = below - 1;
    if (bin < 0) bin = 0;
    binx = bin % bx;
    biny = bin / bx;
    xs = longint'($signed(x_low_m)) + binx * longint'(x_width_m);
    e0 = cdf_tbl[bin];
    e1 = cdf_tbl[bin+1];
    if (ra > e0) begin
      if (e1 > e0) xs += (longint'(x_width_m) * longint'(ra - e0)) / longint'(e1 - e0);
      else s.st = ST_ZERO;
    end
    ys = longint'($signed(y_low_m)) + biny * longint'(y_width_m)
       + ((longint'(y_width_m) * longint'(rb)) >>> PROB_BITS);
    s.x = sat32(xs);
    s.y = sat32(ys);
    return s;
  endfunction

  task automatic send_req(logic fn, logic [12:0] idx, logic [16:0] val,
                          logic [16:0] ra, logic [15:0] rb);
    int      gap;
    sample_t s;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {1'b0, rb, ra, val, idx};
    do @(posedge clk); while (!in_tready);
    if (fn == FUNC_LOAD) begin
      if (idx <= MAX_BINS) cdf_tbl[idx] = val;
      s.x = '0;
      s.y = '0;
      s.st = ST_LOAD;
      n_loads++;
    end else begin
      s = predict_sample(ra, rb);
      n_draws++;
    end
    samples_due = {samples_due, s};
  endtask

  task automatic load(int idx, int val);
    send_req(FUNC_LOAD, idx[12:0], val[16:0], 17'($urandom), 16'($urandom));
  endtask

  task automatic draw(int ra, int rb);
    send_req(~FUNC_LOAD, 13'($urandom), 17'($urandom), ra[16:0], rb[15:0]);
  endtask

  // loads, as entry i = 16 * i, the entries a draw of ra touches in an n-entry search
  task automatic load_path(int n, int ra);
    int above, below, mid, bin;
    above = n + 1;
    below = 0;
    bin = -1;
    load(n, n * 16);
    while (bin < 0 && above - below > 1) begin
      mid = (above + below) / 2;
      load(mid - 1, (mid - 1) * 16);
      if (ra == (mid - 1) * 16) bin = mid - 1;
      else if (ra < (mid - 1) * 16) above = mid;
      else below = mid;
    end
    if (bin < 0) bin = (below == 0) ? 0 : below - 1;
    load(bin, bin * 16);
    load(bin + 1, (bin + 1) * 16);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (addr)
      REG_BINS_X:  bins_x_m  = data[12:0];
      REG_BINS_Y:  bins_y_m  = data[12:0];
      REG_X_LOW:   x_low_m   = data;
      REG_X_WIDTH: x_width_m = data[30:0];
      REG_Y_LOW:   y_low_m   = data;
      REG_Y_WIDTH: y_width_m = data[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(int bx, int by, int xl, int xw, int yl, int yw);
    write_reg(REG_BINS_X, bx);
    write_reg(REG_BINS_Y, by);
    write_reg(REG_X_LOW, xl);
    write_reg(REG_X_WIDTH, xw);
    write_reg(REG_Y_LOW, yl);
    write_reg(REG_Y_WIDTH, yw);
  endtask

  function automatic int table_size();
    longint bx, by, n;
    bx = (bins_x_m == 0) ? 1 : bins_x_m;
    by = (bins_y_m == 0) ? 1 : bins_y_m;
    if (bx > MAX_BINS) bx = MAX_BINS;
    if (by > MAX_BINS) by = MAX_BINS;
    n = bx * by;
    return (n > MAX_BINS) ? MAX_BINS : int'(n);
  endfunction

  // fills entries 0..n: mostly rising, sometimes flat steps, empty or scrambled
  task automatic fill_table(int n);
    int acc, kind, step;
    kind = $urandom_range(0, 9);
    acc = 0;
    for (int i = 0; i <= n; i++) begin
      step = $urandom_range(0, 2 * 65536 / (n + 1) + 1);
      if ($urandom_range(0, 5) == 0) step = 0;
      acc += step;
      if (acc > 131071) acc = 131071;
      if (kind == 0) load(i, (i == n) ? 0 : acc);
      else if (kind == 1) load(i, $urandom_range(0, 131071));
      else if (i == 0) load(i, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : 0);
      else if (i == n && kind < 6) load(i, 65536);
      else load(i, acc);
    end
  endtask

  function automatic int rand_a_value();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(65537, 131071);
      2: return 65536;
      default: return $urandom_range(1, 65536);
    endcase
  endfunction

  task automatic test_defaults();
    load(0, 0);
    load(1, 65536);
    draw(1, 0);
    draw(65536, 65535);
    draw(0, 32768);
    draw(131071, 1);
    draw(32768, 16'hffff);
    load(8191, 131071);
    load(MAX_BINS + 1, 5);
    draw(100, 100);
    wait_idle();
  endtask

  task automatic test_empty_total();
    load(1, 0);
    draw(500, 500);
    load(0, 5000);
    load(1, 65536);
    draw(0, 0);
    draw(4000, 0);
    wait_idle();
  endtask

  task automatic test_flat_step();
    set_config(2, 1, -1000, 65536, 1000, 65536);
    load(0, 0);
    load(1, 1000);
    load(2, 1000);
    draw(5000, 7);
    draw(1000, 7);
    draw(500, 7);
    wait_idle();
  endtask

  task automatic test_bin_limits();
    set_config(0, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    load(0, 0);
    load(1, 65536);
    draw(40000, 65535);
    draw(1, 0);
    wait_idle();
    set_config(8191, 4096, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0);
    load_path(MAX_BINS, 65536);
    draw(65536, 65535);
    load_path(MAX_BINS, 1);
    draw(1, 0);
    load_path(MAX_BINS, 16 * 4095 + 3);
    draw(16 * 4095 + 3, 100);
    load_path(MAX_BINS, 8);
    draw(8, 1);
    wait_idle();
    write_reg(REG_BINS_X, 4096);
    write_reg(REG_X_WIDTH, 0);
    load_path(MAX_BINS, 16 * 4000 + 8);
    draw(16 * 4000 + 8, 0);
    load_path(MAX_BINS, 131071);
    draw(131071, 65535);
    wait_idle();
  endtask

  task automatic test_random_phases();
    int sent, n, items;
    sent = 0;
    while (sent < 600) begin
      set_config($urandom_range(0, 8), $urandom_range(0, 4), $urandom,
                 ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1 << 20) : $urandom,
                 $urandom,
                 ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1 << 20) : $urandom);
      n = table_size();
      fill_table(n);
      items = $urandom_range(20, 60);
      for (int k = 0; k < items; k++) begin
        case ($urandom_range(0, 7))
          0: load($urandom_range(0, n), $urandom_range(0, 131071));
          1: load($urandom_range(MAX_BINS + 1, 8191), $urandom_range(0, 131071));
          default: draw(rand_a_value(), $urandom_range(0, 65535));
        endcase
      end
      sent += items + n + 1;
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    set_config(4, 2, 0, 65536, 0, 65536);
    fill_table(8);
    hold_req = 1'b1;
    for (int k = 0; k < 20; k++) draw(rand_a_value(), $urandom_range(0, 65535));
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    fails = 0;
    n_draws = 0;
    n_loads = 0;
    burst_left = 0;
    bins_x_m = 1;
    bins_y_m = 1;
    x_low_m = 0;
    y_low_m = 0;
    x_width_m = 65536;
    y_width_m = 65536;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_empty_total();
    test_flat_step();
    test_bin_limits();
    test_backpressure();
    test_random_phases();
    wait_idle();
    repeat (150) @(posedge clk);
    $display("%0d draws and %0d loads checked; statuses ok/empty/flat/load: %0d/%0d/%0d/%0d",
             n_draws, n_loads, st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
    if (fails == 0) $display("histogram_inverse_cdf_sampler_top_tb passed");
    else $display("histogram_inverse_cdf_sampler_top_tb failed");
    $finish;
  end

  // receiver: cycles through always-ready, coin-flip and mostly-ready phases, and holds off when hold_req is set
  initial begin
    out_tready = 1'b0;
    hold_cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        case ((cycles / 97) % 3)
          0: out_tready <= 1'b1;
          1: out_tready <= $urandom_range(0, 1);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    sample_t s;
    if (rst_n && out_tvalid && out_tready) begin
      if (samples_due.size() == 0) begin
        $error("result with no request pending");
        fails++;
      end else begin
        s = samples_due.pop_front();
        st_seen[out_tuser]++;
        if (out_tdata[31:0] !== s.x) begin
          $error("x_sample expected %h got %h", s.x, out_tdata[31:0]);
          fails++;
        end
        if (out_tdata[63:32] !== s.y) begin
          $error("y_sample expected %h got %h", s.y, out_tdata[63:32]);
          fails++;
        end
        if (out_tuser !== s.st) begin
          $error("status expected %0d got %0d", s.st, out_tuser);
          fails++;
        end
      end
    end
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("histogram_inverse_cdf_sampler_top_tb failed");
      $finish;
    end
  end
endmodule
